// File: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sitd_pkg.sv
package sitd_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BCD_W  = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Add-3 correction of one BCD digit ahead of a doubling shift
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] d);
    bcd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

// File: hw/rtl/sitd_if.sv
// Input channel: one signed integer per transfer.
interface sitd_value_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one ASCII character per transfer.
interface sitd_char_if import sitd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// File: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// in_if carries one VALUE_WIDTH-bit two's complement value per transfer;
// out_if returns its decimal text one character per transfer, most
// significant first, with a leading '-' for negative values and last set on
// the final digit. Leading zeros are dropped; zero gives a single '0'.
// One value is in flight at a time: in_if.ready is high only while the
// converter is idle, though a finished character may still wait on out_if.
// Per value the steps are: accept, bit-serial shift and add-3 conversion, a
// pass that drops leading zeros, then the characters, sign first, one per
// cycle while out_if does not stall (DIGITS = 10 at 32 bits). Characters
// sit in an output register; while the receiver stalls, emission pauses
// and the conversion state holds.
// Reset clears the sequencer and output valid; no clearing pass is needed.
module signed_int_to_decimal_ascii import sitd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sitd_value_if.sink   in_if,
  sitd_char_if.source  out_if
);

`include "assert_macros.svh"

  localparam int unsigned DIGITS    = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned DIG_CNT_W = $clog2(DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic                   neg_q, neg_d;
  logic [DIG_CNT_W-1:0]   dig_q, dig_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic                   in_fire;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   conv_done;
  logic                   shift;
  logic                   skip_zero;
  logic [BCD_W-1:0]       top_digit;

  assign raw      = in_if.value;
  assign mag      = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  assign skip_zero = (top_digit == '0) && (dig_q > DIG_CNT_W'(1));
  assign shift     = ((state_q == ST_SKIP) && skip_zero) ||
                     ((state_q == ST_EMIT) && out_free && !neg_q);

  sitd_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .mag_i       (mag),
    .shift_i     (shift),
    .done_o      (conv_done),
    .top_digit_o (top_digit)
  );

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CONV;
          neg_d   = raw[VALUE_WIDTH-1];
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_SKIP;
          dig_d   = DIG_CNT_W'(DIGITS);
        end
      end
      ST_SKIP: begin
        if (skip_zero) begin
          dig_d = dig_q - DIG_CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_char_d = ASCII_MINUS;
            out_last_d = 1'b0;
            neg_d      = 1'b0;
          end else begin
            out_char_d = ASCII_ZERO | {{(CHAR_W-BCD_W){1'b0}}, top_digit};
            out_last_d = (dig_q == DIG_CNT_W'(1));
            dig_d      = dig_q - DIG_CNT_W'(1);
            if (dig_q == DIG_CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_if.ready      = (state_q == ST_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.char_code = out_char_q;
  assign out_if.last      = out_last_q;

  `ASSERT_IMPLIES(a_minus_not_last,
                  out_valid_q && (out_char_q == ASCII_MINUS), !out_last_q,
                  "minus sign flagged as last character")
  `ASSERT_IMPLIES(a_emit_has_digits, state_q == ST_EMIT, dig_q != '0,
                  "emitting with no digits left")
  `ASSERT_NEXT(a_last_to_idle,
               (state_q == ST_EMIT) && out_free && !neg_q && (dig_q == DIG_CNT_W'(1)),
               (state_q == ST_IDLE) && out_valid_q && out_last_q,
               "final digit did not close the run")
  `ASSERT_NEXT(a_accept_starts_conv, in_fire, state_q == ST_CONV,
               "accepted value did not start conversion")

endmodule

// File: hw/rtl/sitd_dabble.sv
// Bit-serial binary to BCD (shift and add-3), then a digit shift line
// that hands the most significant digit out on each shift.
module sitd_dabble import sitd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DIGITS      = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  input  logic                   shift_i,
  output logic                   done_o,
  output logic [BCD_W-1:0]       top_digit_o
);

  localparam int unsigned BCD_TOT = DIGITS * BCD_W;
  localparam int unsigned CNT_W   = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_q;
  logic [BCD_TOT-1:0]     bcd_q;
  logic [BCD_TOT-1:0]     bcd_adj;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*BCD_W +: BCD_W] = bcd_adjust(bcd_q[i*BCD_W +: BCD_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_TOT-2:0], mag_q[VALUE_WIDTH-1]};
    end else if (shift_i) begin
      bcd_q <= {bcd_q[BCD_TOT-BCD_W-1:0], {BCD_W{1'b0}}};
    end
  end

  assign done_o      = done_q;
  assign top_digit_o = bcd_q[BCD_TOT-1 -: BCD_W];

endmodule
